// ----- rtl/ase_pkg.sv -----
`default_nettype none

package ase_pkg;

    localparam int unsigned WORD_W = 64;

    typedef logic signed [WORD_W-1:0] word_t;

    // One held or travelling element: valid flag plus signed value.
    typedef struct packed {
        logic  valid;
        word_t value;
    } slot_t;

    // Controller commands to the cell row.
    typedef struct packed {
        logic store_en;   // accepted word enters cell 0
        logic shift_en;   // row shifts one cell toward the output
    } ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/ase_cell.sv -----
`default_nettype none

// One sorting cell: keeps the smaller of its held word and the incoming
// word, passes the larger to the next cell. On shift, takes the neighbor's word.
module ase_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire ase_pkg::slot_t  carry_in,
    input  wire ase_pkg::slot_t  next_slot,
    output ase_pkg::slot_t       slot,
    output ase_pkg::slot_t       carry_out
);

    logic            valid_reg;
    logic            valid_next;
    ase_pkg::word_t  value_reg;
    ase_pkg::word_t  value_next;
    logic            cvalid_reg;
    logic            cvalid_next;
    ase_pkg::word_t  cvalue_reg;
    ase_pkg::word_t  cvalue_next;

    always_comb
    begin
        valid_next  = valid_reg;
        value_next  = value_reg;
        cvalid_next = 1'b0;
        cvalue_next = carry_in.value;
        if (shift_en)
        begin
            valid_next = next_slot.valid;
            value_next = next_slot.value;
        end
        else if (carry_in.valid)
        begin
            if (!valid_reg)
            begin
                valid_next = 1'b1;
                value_next = carry_in.value;
            end
            else if ($signed(carry_in.value) < $signed(value_reg))
            begin
                value_next  = carry_in.value;
                cvalid_next = 1'b1;
                cvalue_next = value_reg;
            end
            else
            begin
                cvalid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            cvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            cvalid_reg <= cvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        cvalue_reg <= cvalue_next;
    end

    assign slot.valid      = valid_reg;
    assign slot.value      = value_reg;
    assign carry_out.valid = cvalid_reg;
    assign carry_out.value = cvalue_reg;

endmodule

`default_nettype wire

// ----- rtl/ase_ctrl.sv -----
`default_nettype none

// Run controller: element count, overflow flag, load / settle / drain.
module ase_ctrl
#(
    parameter int unsigned MAX_ITEMS = 64
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           last_item,
    input  wire logic           out_stall,
    input  wire logic           busy,
    output ase_pkg::ctrl_t      ctrl,
    output logic                in_stall,
    output logic                out_valid,
    output logic                last_result,
    output logic                dropped
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    ase_pkg::state_t  state_reg;
    ase_pkg::state_t  state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             in_acc;
    logic             out_acc;
    logic             room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ase_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        room        = (count_reg < CNT_W'(MAX_ITEMS));
        in_acc      = 1'b0;
        out_acc     = 1'b0;
        unique case (state_reg)
            ase_pkg::ST_LOAD:
            begin
                in_stall = 1'b0;
                in_acc   = in_valid;
                if (in_acc)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        state_next = ase_pkg::ST_SETTLE;
                    end
                end
            end
            ase_pkg::ST_SETTLE:
            begin
                if (!busy)
                begin
                    state_next = ase_pkg::ST_DRAIN;
                end
            end
            ase_pkg::ST_DRAIN:
            begin
                out_valid = 1'b1;
                out_acc   = !out_stall;
                if (out_acc)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        ovf_next   = 1'b0;
                        state_next = ase_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ase_pkg::ST_LOAD;
            end
        endcase
        ctrl.store_en = in_acc & room;
        ctrl.shift_en = out_acc;
    end

    assign last_result = (count_reg == CNT_W'(1));
    assign dropped     = ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("element count above capacity");

    a_drain_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ase_pkg::ST_DRAIN) |-> !busy)
        else $error("drain started with words still moving in the row");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ase_pkg::ST_DRAIN) |-> (count_reg != '0))
        else $error("drain with empty store");

    a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last_result) |=> (state_reg == ase_pkg::ST_LOAD)
            && (count_reg == '0) && !ovf_reg)
        else $error("run not closed after final word");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> (count_reg == CNT_W'(MAX_ITEMS)))
        else $error("overflow flagged before store full");

endmodule

`default_nettype wire

// ----- rtl/ascending_sort_engine.sv -----
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    value, last_item
// out      source     out_valid / out_stall  sorted_value, last_result, dropped
//
// Loading takes one word per cycle; each word ripples down a row of
// MAX_ITEMS compare-and-swap cells, one cell per cycle, behind the last.
// After the last-flagged word the input stalls while the row settles and
// while the run drains smallest first, one word per cycle from cell 0,
// following out_stall; the input reopens the cycle after the final word
// leaves. Reset clears the valid flags, count and overflow flag; cell
// values are not reset. Words arriving at a full store are discarded
// and flagged.
module ascending_sort_engine
#(
    parameter int unsigned MAX_ITEMS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [63:0]    value,
    input  wire logic                  last_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [63:0]         sorted_value,
    output logic                       last_result,
    output logic                       dropped
);

    ase_pkg::ctrl_t ctrl;
    ase_pkg::slot_t slots  [MAX_ITEMS+1];
    ase_pkg::slot_t carries[MAX_ITEMS+1];
    logic           busy;

    // Cell 0 takes the accepted word; past the last cell the row reads empty.
    assign carries[0].valid       = ctrl.store_en;
    assign carries[0].value       = value;
    assign slots[MAX_ITEMS].valid = 1'b0;
    assign slots[MAX_ITEMS].value = '0;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        ase_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (ctrl.shift_en),
            .carry_in  (carries[i]),
            .next_slot (slots[i+1]),
            .slot      (slots[i]),
            .carry_out (carries[i+1])
        );
    end

    // Any word still traveling between cells.
    always_comb
    begin
        busy = 1'b0;
        for (int i = 1; i <= MAX_ITEMS; i++)
        begin
            busy = busy | carries[i].valid;
        end
    end

    ase_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_item   (last_item),
        .out_stall   (out_stall),
        .busy        (busy),
        .ctrl        (ctrl),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .last_result (last_result),
        .dropped     (dropped)
    );

    // Cell 0 holds the smallest remaining word, straight from its register.
    assign sorted_value = slots[0].value;

endmodule

`default_nettype wire
